>>> sv/symmetric_3x3_inverse_top_assert.svh
// Assertion macros for the symmetric 3x3 inverse block.
`ifndef SYMMETRIC_3X3_INVERSE_TOP_ASSERT_SVH
`define SYMMETRIC_3X3_INVERSE_TOP_ASSERT_SVH
// combinational or implication property, checked every clock out of reset
`define SYM3I_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// property checked on the cycle after the trigger
`define SYM3I_ASSERT_NEXT(lbl, trig, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error(msg);
`endif

>>> sv/sym3i_pkg.sv
// Shared types, widths and tables for the symmetric 3x3 inverse block.
package sym3i_pkg;
	localparam int MatN      = 3;
	localparam int ElemW     = 16;
	localparam int ProdW     = 2 * ElemW;
	localparam int CofW      = ProdW + 1;
	localparam int DetProdW  = CofW + ElemW;
	localparam int DetW      = DetProdW + 2;
	localparam int DenW      = DetW - 1;
	localparam int QShift    = 28;
	localparam int MagW      = CofW - 1;
	localparam int NumW      = MagW + QShift;
	localparam int QW        = 32;
	localparam int CmpW      = DenW + QW;
	localparam int DivLat    = QW + 2;
	localparam int NumProd   = 16;
	localparam int NumCof    = 8;
	localparam int NumOut    = 6;
	localparam int FrontLat  = 5;
	localparam int CtlLat    = FrontLat + DivLat;

	localparam logic [QW-1:0] QMax = {1'b0, {(QW-1){1'b1}}};
	localparam logic [QW-1:0] QMin = {1'b1, {(QW-1){1'b0}}};

	typedef logic signed [ElemW-1:0] elem_t;
	typedef logic signed [CofW-1:0]  cof_t;

	typedef enum logic [1:0] {
		StOk       = 2'd0,
		StNotSym   = 2'd1,
		StSingular = 2'd2
	} status_t;

	typedef struct packed {
		logic    vld;
		status_t status;
	} ctl_t;

	// product operand indices (row*3+col); cofactor k = prod[2k] - prod[2k+1]
	// cofactor order: c00 c01 c02 c10 c20 c11 c21 c22
	localparam logic [3:0] ProdA [NumProd] = '{4'd4, 4'd7, 4'd5, 4'd8, 4'd3, 4'd6,
		4'd7, 4'd1, 4'd1, 4'd4, 4'd8, 4'd2, 4'd2, 4'd5, 4'd0, 4'd3};
	localparam logic [3:0] ProdB [NumProd] = '{4'd8, 4'd5, 4'd6, 4'd3, 4'd7, 4'd4,
		4'd2, 4'd8, 4'd5, 4'd2, 4'd0, 4'd6, 4'd3, 4'd0, 4'd4, 4'd1};
	// cofactors feeding the outputs inv00 inv01 inv02 inv11 inv12 inv22
	localparam logic [2:0] OutCof [NumOut] = '{3'd0, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7};
endpackage

>>> sv/sym3i_cof.sv
// Cofactor stages: element products, then cofactor differences.
module sym3i_cof (
	input  logic              clk,
	input  logic              en,
	input  sym3i_pkg::elem_t  m [9],
	output sym3i_pkg::cof_t   cof_s2 [sym3i_pkg::NumCof],
	output sym3i_pkg::elem_t  row0_s2 [sym3i_pkg::MatN]
);
	logic signed [sym3i_pkg::ProdW-1:0] prod_s1 [sym3i_pkg::NumProd];
	sym3i_pkg::elem_t                   row0_s1 [sym3i_pkg::MatN];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < sym3i_pkg::NumProd; k++) begin
				prod_s1[k] <= m[sym3i_pkg::ProdA[k]] * m[sym3i_pkg::ProdB[k]];
			end
			for (int j = 0; j < sym3i_pkg::MatN; j++) begin
				row0_s1[j] <= m[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < sym3i_pkg::NumCof; k++) begin
				cof_s2[k] <= sym3i_pkg::CofW'(prod_s1[2*k]) - sym3i_pkg::CofW'(prod_s1[2*k+1]);
			end
			row0_s2 <= row0_s1;
		end
	end
endmodule

>>> sv/sym3i_det.sv
// Determinant along row 0, then magnitudes and signs for the dividers.
module sym3i_det (
	input  logic                        clk,
	input  logic                        en,
	input  sym3i_pkg::cof_t             cof_s2 [sym3i_pkg::NumCof],
	input  sym3i_pkg::elem_t            row0_s2 [sym3i_pkg::MatN],
	output logic [sym3i_pkg::NumW-1:0]  num_s5 [sym3i_pkg::NumOut],
	output logic                        neg_s5 [sym3i_pkg::NumOut],
	output logic [sym3i_pkg::DenW-1:0]  den_s5,
	output logic                        zero_s5
);
	logic signed [sym3i_pkg::DetProdW-1:0] dp_s3 [sym3i_pkg::MatN];
	sym3i_pkg::cof_t                       cof_s3 [sym3i_pkg::NumOut];
	sym3i_pkg::cof_t                       cof_s4 [sym3i_pkg::NumOut];
	logic signed [sym3i_pkg::DetW-1:0]     det_s4;
	logic [sym3i_pkg::MagW-1:0]            mag [sym3i_pkg::NumOut];
	logic [sym3i_pkg::DetW-1:0]            det_abs;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < sym3i_pkg::MatN; j++) begin
				dp_s3[j] <= sym3i_pkg::DetProdW'(row0_s2[j])
					* sym3i_pkg::DetProdW'(cof_s2[j]);
			end
			for (int k = 0; k < sym3i_pkg::NumOut; k++) begin
				cof_s3[k] <= cof_s2[sym3i_pkg::OutCof[k]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s4 <= sym3i_pkg::DetW'(dp_s3[0]) + sym3i_pkg::DetW'(dp_s3[1])
				+ sym3i_pkg::DetW'(dp_s3[2]);
			cof_s4 <= cof_s3;
		end
	end

	always_comb begin
		for (int k = 0; k < sym3i_pkg::NumOut; k++) begin
			mag[k] = cof_s4[k][sym3i_pkg::CofW-1] ? sym3i_pkg::MagW'(-cof_s4[k])
				: sym3i_pkg::MagW'(cof_s4[k]);
		end
		det_abs = det_s4[sym3i_pkg::DetW-1] ? -det_s4 : det_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < sym3i_pkg::NumOut; k++) begin
				num_s5[k] <= {mag[k], {sym3i_pkg::QShift{1'b0}}};
				neg_s5[k] <= cof_s4[k][sym3i_pkg::CofW-1] ^ det_s4[sym3i_pkg::DetW-1];
			end
			den_s5  <= det_abs[sym3i_pkg::DenW-1:0];
			zero_s5 <= (det_s4 == '0);
		end
	end
endmodule

>>> sv/sym3i_div.sv
// Pipelined restoring divider, one quotient bit per stage, with Q4.28 saturation.
module sym3i_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [sym3i_pkg::NumW-1:0]  num,
	input  logic [sym3i_pkg::DenW-1:0]  den,
	input  logic                        neg,
	output logic [sym3i_pkg::QW-1:0]    res
);
	localparam int QW = sym3i_pkg::QW;

	logic [sym3i_pkg::NumW-1:0] rem_s [QW+1];
	logic [sym3i_pkg::DenW-1:0] den_s [QW+1];
	logic [QW-1:0]              quo_s [QW+1];
	logic                       neg_s [QW+1];
	logic                       ovf_s [QW+1];

	// quotient at or above 2^32 saturates regardless of the bits below
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			quo_s[0] <= '0;
			neg_s[0] <= neg;
			ovf_s[0] <= sym3i_pkg::CmpW'(num) >= {den, {QW{1'b0}}};
		end
	end

	for (genvar i = 0; i < QW; i++) begin : g_bit
		logic [sym3i_pkg::CmpW-1:0] dsh;
		logic                       ge;
		assign dsh = sym3i_pkg::CmpW'(den_s[i]) << (QW - 1 - i);
		assign ge  = sym3i_pkg::CmpW'(rem_s[i]) >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? rem_s[i] - dsh[sym3i_pkg::NumW-1:0] : rem_s[i];
				quo_s[i+1] <= {quo_s[i][QW-2:0], ge};
				den_s[i+1] <= den_s[i];
				neg_s[i+1] <= neg_s[i];
				ovf_s[i+1] <= ovf_s[i];
			end
		end
	end

	logic [QW-1:0] q;
	assign q = quo_s[QW];

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s[QW]) begin
				res <= (ovf_s[QW] || (q[QW-1] && (q[QW-2:0] != '0))) ? sym3i_pkg::QMin : -q;
			end else begin
				res <= (ovf_s[QW] || q[QW-1]) ? sym3i_pkg::QMax : q;
			end
		end
	end
endmodule

>>> sv/symmetric_3x3_inverse_top.sv
// Throughput: one beat per cycle unless the output stalls; the whole pipeline advances together.
// Depth is set by the 32-stage restoring dividers, one quotient bit each.
// A stalled output register holds every stage; ready drops only then.
// Reset (arst_n low, asynchronous) clears all valid bits; data regs are not reset.
// Top level of the symmetric 3x3 inverse block.
`include "symmetric_3x3_inverse_top_assert.svh"
module symmetric_3x3_inverse_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] e00,
	input  logic [15:0] e01,
	input  logic [15:0] e02,
	input  logic [15:0] e10,
	input  logic [15:0] e11,
	input  logic [15:0] e12,
	input  logic [15:0] e20,
	input  logic [15:0] e21,
	input  logic [15:0] e22,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] inv00,
	output logic [31:0] inv01,
	output logic [31:0] inv02,
	output logic [31:0] inv11,
	output logic [31:0] inv12,
	output logic [31:0] inv22,
	output logic [1:0]  status
);
	localparam int NumOut = sym3i_pkg::NumOut;
	localparam int CtlLat = sym3i_pkg::CtlLat;

	logic                              adv;
	sym3i_pkg::elem_t                  m [9];
	sym3i_pkg::cof_t                   cof_s2 [sym3i_pkg::NumCof];
	sym3i_pkg::elem_t                  row0_s2 [sym3i_pkg::MatN];
	logic [sym3i_pkg::NumW-1:0]        num_s5 [NumOut];
	logic                              neg_s5 [NumOut];
	logic [sym3i_pkg::DenW-1:0]        den_s5;
	logic                              zero_s5;
	logic [sym3i_pkg::QW-1:0]          res [NumOut];
	sym3i_pkg::ctl_t                   ctl_s [1:CtlLat];
	logic [sym3i_pkg::QW-1:0]          inv_q [NumOut];
	sym3i_pkg::status_t                status_q;
	logic                              out_valid_q;
	logic                              sym;

	// every stage moves when the output register is empty or being drained
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	assign m = '{e00, e01, e02, e10, e11, e12, e20, e21, e22};
	// symmetry on raw bit patterns
	assign sym = (e01 == e10) && (e02 == e20) && (e12 == e21);

	sym3i_cof u_cof (
		.clk     (clk),
		.en      (adv),
		.m       (m),
		.cof_s2  (cof_s2),
		.row0_s2 (row0_s2)
	);

	sym3i_det u_det (
		.clk     (clk),
		.en      (adv),
		.cof_s2  (cof_s2),
		.row0_s2 (row0_s2),
		.num_s5  (num_s5),
		.neg_s5  (neg_s5),
		.den_s5  (den_s5),
		.zero_s5 (zero_s5)
	);

	for (genvar k = 0; k < NumOut; k++) begin : g_div
		sym3i_div u_div (
			.clk (clk),
			.en  (adv),
			.num (num_s5[k]),
			.den (den_s5),
			.neg (neg_s5[k]),
			.res (res[k])
		);
	end

	// control line: valid and status travel beside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 1; s <= CtlLat; s++) begin
				ctl_s[s] <= '{vld: 1'b0, status: sym3i_pkg::StOk};
			end
		end else if (adv) begin
			ctl_s[1] <= '{vld: in_valid,
				status: sym ? sym3i_pkg::StOk : sym3i_pkg::StNotSym};
			for (int s = 2; s <= CtlLat; s++) begin
				if (s != sym3i_pkg::FrontLat + 1) begin
					ctl_s[s] <= ctl_s[s-1];
				end
			end
			// singular is known once the determinant lands in stage 5
			ctl_s[sym3i_pkg::FrontLat+1] <= '{vld: ctl_s[sym3i_pkg::FrontLat].vld,
				status: (ctl_s[sym3i_pkg::FrontLat].status == sym3i_pkg::StOk && zero_s5)
				? sym3i_pkg::StSingular : ctl_s[sym3i_pkg::FrontLat].status};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			status_q    <= sym3i_pkg::StOk;
		end else if (adv) begin
			out_valid_q <= ctl_s[CtlLat].vld;
			status_q    <= ctl_s[CtlLat].status;
		end
	end

	// payload of the output beat; nonzero status forces all entries to zero
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NumOut; k++) begin
				inv_q[k] <= (ctl_s[CtlLat].status == sym3i_pkg::StOk) ? res[k] : '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign inv00     = inv_q[0];
	assign inv01     = inv_q[1];
	assign inv02     = inv_q[2];
	assign inv11     = inv_q[3];
	assign inv12     = inv_q[4];
	assign inv22     = inv_q[5];

	`SYM3I_ASSERT(a_ready_only_stall, !in_ready |-> (out_valid && !out_ready), "ready low without output stall")
	`SYM3I_ASSERT(a_bad_zero, (out_valid && status != sym3i_pkg::StOk) |-> (inv00 == '0 && inv11 == '0 && inv22 == '0), "nonzero entries with error status")
	`SYM3I_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(inv01), "stalled result changed")
endmodule

>>> dv/sym3i_inverse_checker.sv
// Checker for the symmetric 3x3 inverse block: predicts each result and compares it.
`timescale 1ns / 100ps
module sym3i_inverse_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [15:0] e00, e01, e02, e10, e11, e12, e20, e21, e22,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] inv00, inv01, inv02, inv11, inv12, inv22,
	input  logic [1:0]  status,
	output int          fail_count,
	output int          pending
);
	import sym3i_pkg::*;

	typedef struct packed {
		logic [31:0] i00, i01, i02, i11, i12, i22;
		status_t     st;
	} inverse_t;

	inverse_t expected_inverses[$];
	int mismatches = 0;

	assign pending = expected_inverses.size();
	assign fail_count = mismatches;

	// truncating division then clamp to Q4.28 range
	function automatic logic [31:0] scaled_quotient(longint cof, longint det);
		longint q;
		q = (cof * (64'sd1 <<< QShift)) / det;
		if (q > 64'sd2147483647) q = 64'sd2147483647;
		if (q < -64'sd2147483648) q = -64'sd2147483648;
		return q[31:0];
	endfunction

	function automatic inverse_t predict_inverse(logic [15:0] raw [9]);
		longint a [3][3];
		longint c [3][3];
		longint det;
		inverse_t r;
		r = '0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				a[i][j] = longint'($signed(raw[i*3+j]));
		if (raw[1] != raw[3] || raw[2] != raw[6] || raw[5] != raw[7]) begin
			r.st = StNotSym;
			return r;
		end
		// cyclic indices carry the cofactor sign
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				c[i][j] = a[(i+1)%3][(j+1)%3] * a[(i+2)%3][(j+2)%3]
					- a[(i+2)%3][(j+1)%3] * a[(i+1)%3][(j+2)%3];
		det = a[0][0]*c[0][0] + a[0][1]*c[0][1] + a[0][2]*c[0][2];
		if (det == 0) begin
			r.st = StSingular;
			return r;
		end
		r.i00 = scaled_quotient(c[0][0], det);
		r.i01 = scaled_quotient(c[1][0], det);
		r.i02 = scaled_quotient(c[2][0], det);
		r.i11 = scaled_quotient(c[1][1], det);
		r.i12 = scaled_quotient(c[2][1], det);
		r.i22 = scaled_quotient(c[2][2], det);
		r.st = StOk;
		return r;
	endfunction

	always @(posedge clk) begin
		logic [15:0] raw [9];
		inverse_t want, got;
		if (arst_n && in_valid && in_ready) begin
			raw = '{e00, e01, e02, e10, e11, e12, e20, e21, e22};
			expected_inverses.push_back(predict_inverse(raw));
		end
		if (arst_n && out_valid && out_ready) begin
			got = '{inv00, inv01, inv02, inv11, inv12, inv22, status_t'(status)};
			if (expected_inverses.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %p", got);
			end else begin
				want = expected_inverses.pop_front();
				if (want !== got) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", want, got);
				end
			end
		end
	end
endmodule

>>> dv/tb_symmetric_3x3_inverse_top.sv
// Testbench top for the symmetric 3x3 inverse block: stimulus and verdict.
`timescale 1ns / 100ps
module tb_symmetric_3x3_inverse_top;
	import sym3i_pkg::*;

	localparam int NumRandom = 1800;
	localparam int WatchLimit = 5000;
	localparam int DrainCycles = 60;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [15:0] e00 = 0, e01 = 0, e02 = 0, e10 = 0, e11 = 0, e12 = 0, e20 = 0, e21 = 0,
		e22 = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [31:0] inv00, inv01, inv02, inv11, inv12, inv22;
	logic [1:0] status;
	int fail_count, pending;
	int idle_cycles = 0;
	// mode for the receiver: 0 random stalls, 1 long hold-off, 2 always ready
	int sink_mode = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	symmetric_3x3_inverse_top u_top (.*);

	sym3i_inverse_checker u_chk (.*);

	// watchdog: cycles without any beat on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: random stall before each beat
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (sink_mode == 1) begin
				out_ready <= 0;
				repeat (300) @(posedge clk);
				sink_mode = 0;
			end
			gap = (sink_mode == 2 || $urandom_range(3) == 0) ? 0 : $urandom_range(19);
			out_ready <= 0;
			repeat (gap) @(posedge clk);
			out_ready <= 1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// present one matrix and hold it until accepted
	task automatic send_matrix(logic [15:0] m [9], int gap);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		{e00, e01, e02, e10, e11, e12, e20, e21, e22} <=
			{m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_symmetric(logic [15:0] d0, d1, d2, o01, o02, o12, int gap);
		logic [15:0] m [9];
		m = '{d0, o01, o02, o01, d1, o12, o02, o12, d2};
		send_matrix(m, gap);
	endtask

	function automatic logic [15:0] random_elem();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'(int'($urandom_range(8)) - 4);
			4: return 16'h1000;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [15:0] m [9];
		int gap;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: identity, scaled identity, extremes, singular, asymmetric
		sink_mode = 2;
		send_symmetric(16'h1000, 16'h1000, 16'h1000, 0, 0, 0, 0);
		send_symmetric(16'hf000, 16'h2000, 16'h0800, 0, 0, 0, 0);
		send_symmetric(16'h7fff, 16'h7fff, 16'h7fff, 0, 0, 0, 0);
		send_symmetric(16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 0);
		send_symmetric(16'h0001, 16'h0001, 16'h0001, 0, 0, 0, 0);
		send_symmetric(16'h0001, 16'h7fff, 16'h8000, 0, 0, 0, 0);
		send_symmetric(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 0);
		send_symmetric(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 0);
		send_symmetric(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
		send_symmetric(0, 0, 0, 0, 0, 0, 0);
		send_symmetric(16'h1000, 16'h1000, 16'h1000, 16'h1000, 16'h1000, 16'h1000, 0);
		send_symmetric(16'h1000, 16'h1000, 16'h1000, 16'h1000, 0, 0, 0);
		send_symmetric(16'h1000, 16'h0001, 16'h0001, 0, 0, 16'h0001, 0);
		send_symmetric(16'h0001, 16'h0001, 16'h0001, 16'h0001, 0, 0, 0);
		m = '{16'h1000, 16'h0001, 0, 16'h0002, 16'h1000, 0, 0, 0, 16'h1000};
		send_matrix(m, 0);
		m = '{16'h1000, 0, 16'h8000, 0, 16'h1000, 0, 16'h7fff, 0, 16'h1000};
		send_matrix(m, 0);
		m = '{16'h1000, 0, 0, 0, 16'h1000, 16'hffff, 0, 16'h7fff, 16'h1000};
		send_matrix(m, 0);
		m = '{16'hffff, 16'hffff, 16'hffff, 16'hfffe, 16'hffff, 16'hffff, 16'hffff,
			16'hffff, 16'hffff};
		send_matrix(m, 0);
		sink_mode = 0;

		for (int n = 0; n < NumRandom; n++) begin
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(19);
			if (n == 400) begin
				// long receiver hold-off while we push back-to-back
				sink_mode = 1;
			end
			if (n >= 400 && n < 480) gap = 0;
			if (n == 900) begin
				// sender pause until every expected result is back
				in_valid <= 0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			if (n >= 1200 && n < 1300) gap = 0;
			if ($urandom_range(9) == 0) begin
				for (int k = 0; k < 9; k++) m[k] = 16'($urandom);
				send_matrix(m, gap);
			end else if ($urandom_range(9) == 0) begin
				// singular: rows 0 and 1 are duplicates
				m[0] = random_elem();
				send_symmetric(m[0], m[0], random_elem(), m[0], 0, 0, gap);
			end else begin
				send_symmetric(random_elem(), random_elem(), random_elem(),
					random_elem(), random_elem(), random_elem(), gap);
			end
		end
		in_valid <= 0;
		@(posedge clk);

		while (pending != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
